>>> rtl/cai_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cai_pkg;

	localparam int STEPS     = 1000;
	localparam int STEP_W    = $clog2(STEPS);
	localparam int REM_W     = $clog2(2 * STEPS);
	localparam int A_W       = 26;
	localparam int AGE_W     = 36;
	localparam int H0_W      = 8;
	localparam int WM_W      = 16;
	localparam int WR_W      = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int X_W       = 42;
	localparam int X2_W      = 52;
	localparam int X4_W      = 56;
	localparam int MT_W      = 50;
	localparam int KT_W      = 54;
	localparam int VT_W      = 56;
	localparam int WK_W      = 34;
	localparam int D_W       = 60;
	localparam int SQ_W      = 58;
	localparam int ROOT_W    = 29;
	localparam int DIV_N_W   = 64;
	localparam int DIV_D_W   = 30;

	// reciprocal of STEPS, scaled by 2^RECIP_SH and rounded up
	localparam int RECIP_SH = 63 + STEP_W;
	localparam logic [63:0] RECIP_STEPS =
		64'(((128'd1 << RECIP_SH) + 128'(STEPS) - 128'd1) / 128'(STEPS));
	localparam logic [63:0] YEARS_NUM = 64'd977800000000;
	localparam logic [63:0] AGE_MAX   = 64'h0000_000F_FFFF_FFFF;

	localparam logic [H0_W-1:0] HUBBLE_RST = 8'd67;
	localparam logic [WM_W-1:0] MATTER_RST = 16'd20808;
	localparam logic [WM_W-1:0] VACUUM_RST = 16'd44728;
	localparam logic [WR_W-1:0] RADIATION_RST = 32'd398501;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HUBBLE,
		CFG_MATTER,
		CFG_VACUUM,
		CFG_RADIATION
	} cfg_idx_t;

	typedef enum logic {
		DIV_TERM,
		DIV_YEARS
	} div_sel_t;

	typedef enum logic [1:0] {
		MUL_X0,
		MUL_MEAN,
		MUL_T,
		MUL_Y
	} mul_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_X0_GO,
		ST_X0_WAIT,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_P4,
		ST_CHK,
		ST_SQ_WAIT,
		ST_DV_WAIT,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_TM_GO,
		ST_TM_WAIT,
		ST_YM_GO,
		ST_YM_WAIT,
		ST_HD_GO,
		ST_HD_WAIT,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     x0_cap;
		logic     p1;
		logic     p2;
		logic     p3;
		logic     p4;
		logic     sqrt_start;
		logic     acc;
		logic     adv;
		logic     m_cap;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     t_cap;
		logic     y_cap;
		logic     yr_cap;
		logic     sat_max;
		logic     out_load;
	} cai_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic mul_done;
		logic d_pos;
		logic last;
		logic h0_zero;
	} cai_sts_t;

endpackage
`default_nettype wire

>>> rtl/cai_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cai_in_if;
	logic                     valid;
	logic                     ready;
	logic [cai_pkg::A_W-1:0]  scale_factor;

	modport source (output valid, output scale_factor, input ready);
	modport sink (input valid, input scale_factor, output ready);
endinterface
`default_nettype wire

>>> rtl/cai_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cai_out_if;
	logic                       valid;
	logic                       ready;
	logic [cai_pkg::AGE_W-1:0]  age_years;

	modport source (output valid, output age_years, input ready);
	modport sink (input valid, input age_years, output ready);
endinterface
`default_nettype wire

>>> rtl/cai_div.sv
`timescale 1ns / 1ps
`default_nettype none
module cai_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [cai_pkg::DIV_N_W-1:0]   dividend,
	input  wire logic [cai_pkg::DIV_D_W-1:0]   divisor,
	output logic                               done,
	output logic [cai_pkg::DIV_N_W-1:0]        quot
);
	localparam int N = cai_pkg::DIV_N_W;
	localparam int M = cai_pkg::DIV_D_W;
	localparam int C_W = $clog2(N);

	logic [M-1:0] rem_q;
	logic [N-1:0] quo_q;
	logic [M-1:0] dvs_q;
	logic [C_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [M:0] trial;
	logic [M:0] diff;
	logic ge;

	assign trial = {rem_q, quo_q[N-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + C_W'(1);
				if (cnt_q == C_W'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[M-1:0] : trial[M-1:0];
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule
`default_nettype wire

>>> rtl/cai_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module cai_sqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [cai_pkg::SQ_W-1:0]     radicand,
	output logic                              done,
	output logic [cai_pkg::ROOT_W-1:0]        root
);
	localparam int W = cai_pkg::SQ_W;

	logic [W-1:0] v_q;
	logic [W-1:0] r_q;
	logic [W-1:0] b_q;
	logic busy_q;
	logic done_q;
	logic [W-1:0] rb;

	assign rb = r_q + b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// one result bit per cycle, starting at the top even power
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			r_q <= '0;
			b_q <= W'(1) << (W - 2);
		end else if (busy_q) begin
			if (v_q >= rb) begin
				v_q <= v_q - rb;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[cai_pkg::ROOT_W-1:0];
endmodule
`default_nettype wire

>>> rtl/cai_lmul.sv
`timescale 1ns / 1ps
`default_nettype none
module cai_lmul (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [63:0]   p,
	input  wire logic [63:0]   q,
	output logic               done,
	output logic [127:0]       prod
);
	logic [63:0] p_q;
	logic [63:0] q_q;
	logic [1:0] phase_q;
	logic run_q;
	logic [63:0] pp_s1;
	logic [1:0] sh_s1;
	logic v_s1;
	logic last_s1;
	logic [127:0] acc_q;
	logic done_q;
	logic [31:0] ph;
	logic [31:0] qh;
	logic [127:0] pp_sh;

	assign ph = phase_q[1] ? p_q[63:32] : p_q[31:0];
	assign qh = phase_q[0] ? q_q[63:32] : q_q[31:0];

	always_comb begin
		case (sh_s1)
			2'd0: pp_sh = {64'b0, pp_s1};
			2'd1: pp_sh = {32'b0, pp_s1, 32'b0};
			2'd2: pp_sh = {pp_s1, 64'b0};
			default: pp_sh = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			phase_q <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= v_s1 && last_s1;
			v_s1    <= run_q;
			last_s1 <= run_q && (phase_q == 2'd3);
			if (start) begin
				run_q   <= 1'b1;
				phase_q <= '0;
			end else if (run_q) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= p;
			q_q <= q;
		end
		pp_s1 <= ph * qh;
		sh_s1 <= 2'(phase_q[1]) + 2'(phase_q[0]);
		if (start) begin
			acc_q <= '0;
		end else if (v_s1) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

>>> rtl/cai_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module cai_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [cai_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  wire logic [cai_pkg::CFG_W-1:0]         cfg_wdata,
	input  wire logic [cai_pkg::A_W-1:0]           scale_factor,
	input  wire cai_pkg::cai_cmd_t                 cmd,
	output cai_pkg::cai_sts_t                      sts,
	output logic [cai_pkg::AGE_W-1:0]              age_years
);
	localparam int XW = cai_pkg::X_W;
	localparam int RW = cai_pkg::REM_W;
	localparam int SH = cai_pkg::RECIP_SH;
	localparam logic [RW:0] TWO_STEPS_R = (RW + 1)'(2 * cai_pkg::STEPS);

	logic [cai_pkg::H0_W-1:0] hub_q;
	logic [cai_pkg::WM_W-1:0] wm_q;
	logic [cai_pkg::WM_W-1:0] wv_q;
	logic [cai_pkg::WR_W-1:0] wr_q;

	logic [cai_pkg::A_W-1:0] a_q;
	logic wk_neg_q;
	logic [cai_pkg::WK_W-1:0] wk_mag_q;
	logic [XW-1:0] x_q;
	logic [RW-1:0] xr_q;
	logic [XW-1:0] qs_q;
	logic [RW-1:0] rs_q;
	logic [cai_pkg::STEP_W-1:0] i_q;
	logic [cai_pkg::X2_W-1:0] x2_q;
	logic [cai_pkg::MT_W-1:0] mt_q;
	logic [cai_pkg::X4_W-1:0] x4_q;
	logic [cai_pkg::KT_W-1:0] kt_q;
	logic [cai_pkg::VT_W-1:0] vt_q;
	logic [cai_pkg::D_W-1:0] d_q;
	logic [63:0] sum_q;
	logic [63:0] val_q;
	logic [cai_pkg::AGE_W-1:0] age_q;

	logic [35:0] wk_u;
	logic [35:0] wk_abs;
	logic [XW-1:0] xe;
	logic [XW-1:0] a16;
	logic [XW-1:0] x0_quo;
	logic [RW-1:0] x0_rem;
	logic [cai_pkg::DIV_N_W-1:0] div_n;
	logic [cai_pkg::DIV_D_W-1:0] div_d;
	logic div_done;
	logic [cai_pkg::DIV_N_W-1:0] div_q;
	logic sqrt_done;
	logic [cai_pkg::ROOT_W-1:0] root;
	logic mul_done;
	logic [63:0] mul_p;
	logic [63:0] mul_q;
	logic [127:0] prod;
	logic [63:0] sq_x;
	logic [63:0] sq_x2;
	logic [57:0] mt_full;
	logic [61:0] kt_full;
	logic [RW:0] r2;
	logic r2_ge;
	logic [RW:0] r2_red;
	logic [RW:0] xr_sum;
	logic xr_wrap;
	logic [RW:0] xr_red;
	logic [cai_pkg::D_W-1:0] d_base;
	logic [64:0] sum_nx;

	// curvature: one minus the other densities, in Q.32
	assign wk_u = 36'h1_0000_0000 - {4'b0, wm_q, 16'b0} - {4'b0, wr_q}
		- {4'b0, wv_q, 16'b0};
	assign wk_abs = wk_u[35] ? (~wk_u + 36'd1) : wk_u;

	assign xe = (x_q == '0) ? XW'(1) : x_q;

	always_comb begin
		case (cmd.div_sel)
			cai_pkg::DIV_TERM: begin
				div_n = 64'({xe, 16'b0});
				div_d = cai_pkg::DIV_D_W'(root);
			end
			cai_pkg::DIV_YEARS: begin
				div_n = val_q;
				div_d = cai_pkg::DIV_D_W'(hub_q);
			end
			default: begin
				div_n = val_q;
				div_d = cai_pkg::DIV_D_W'(hub_q);
			end
		endcase
	end

	// first midpoint and the mean by reciprocal multiplication, then the scale-factor and years products
	assign a16 = {a_q, 16'b0};

	always_comb begin
		case (cmd.mul_sel)
			cai_pkg::MUL_X0: begin
				mul_p = 64'(a16);
				mul_q = cai_pkg::RECIP_STEPS;
			end
			cai_pkg::MUL_MEAN: begin
				mul_p = sum_q;
				mul_q = cai_pkg::RECIP_STEPS;
			end
			cai_pkg::MUL_T: begin
				mul_p = val_q;
				mul_q = 64'(a_q);
			end
			cai_pkg::MUL_Y: begin
				mul_p = val_q;
				mul_q = cai_pkg::YEARS_NUM;
			end
			default: begin
				mul_p = val_q;
				mul_q = 64'(a_q);
			end
		endcase
	end

	cai_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quot     (div_q)
	);

	cai_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (d_q[cai_pkg::SQ_W-1:0]),
		.done     (sqrt_done),
		.root     (root)
	);

	cai_lmul u_lmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.p      (mul_p),
		.q      (mul_q),
		.done   (mul_done),
		.prod   (prod)
	);

	assign sq_x    = xe[41:10] * xe[41:10];
	assign sq_x2   = x2_q[51:20] * x2_q[51:20];
	assign mt_full = wm_q * xe;
	assign kt_full = wk_mag_q * x2_q[51:24];

	assign x0_quo = prod[SH+XW:SH+1];
	assign x0_rem = a16[RW-1:0] - RW'(x0_quo[RW-1:0] * TWO_STEPS_R[RW-1:0]);

	assign r2     = {x0_rem, 1'b0};
	assign r2_ge  = r2 >= TWO_STEPS_R;
	assign r2_red = r2 - TWO_STEPS_R;

	assign xr_sum  = {1'b0, xr_q} + {1'b0, rs_q};
	assign xr_wrap = xr_sum >= TWO_STEPS_R;
	assign xr_red  = xr_sum - TWO_STEPS_R;

	assign d_base = cai_pkg::D_W'({wr_q, 16'b0}) + cai_pkg::D_W'(mt_q)
		+ cai_pkg::D_W'(vt_q);
	assign sum_nx = {1'b0, sum_q} + {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hub_q <= cai_pkg::HUBBLE_RST;
			wm_q  <= cai_pkg::MATTER_RST;
			wv_q  <= cai_pkg::VACUUM_RST;
			wr_q  <= cai_pkg::RADIATION_RST;
		end else if (cfg_wr_en) begin
			case (cai_pkg::cfg_idx_t'(cfg_addr))
				cai_pkg::CFG_HUBBLE:    hub_q <= cfg_wdata[cai_pkg::H0_W-1:0];
				cai_pkg::CFG_MATTER:    wm_q  <= cfg_wdata[cai_pkg::WM_W-1:0];
				cai_pkg::CFG_VACUUM:    wv_q  <= cfg_wdata[cai_pkg::WM_W-1:0];
				cai_pkg::CFG_RADIATION: wr_q  <= cfg_wdata[cai_pkg::WR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q      <= scale_factor;
			wk_neg_q <= wk_u[35];
			wk_mag_q <= wk_abs[cai_pkg::WK_W-1:0];
			i_q      <= '0;
		end
		if (cmd.x0_cap) begin
			x_q  <= x0_quo;
			xr_q <= x0_rem;
			qs_q <= {x0_quo[XW-2:0], 1'b0} + XW'(r2_ge);
			rs_q <= r2_ge ? r2_red[RW-1:0] : r2[RW-1:0];
		end else if (cmd.adv) begin
			x_q  <= x_q + qs_q + XW'(xr_wrap);
			xr_q <= xr_wrap ? xr_red[RW-1:0] : xr_sum[RW-1:0];
			i_q  <= i_q + cai_pkg::STEP_W'(1);
		end
		if (cmd.p1) begin
			x2_q <= sq_x[63:12];
			mt_q <= mt_full[57:8];
		end
		if (cmd.p2) begin
			x4_q <= sq_x2[63:8];
			kt_q <= kt_full[61:8];
		end
		if (cmd.p3) begin
			vt_q <= wv_q * x4_q[55:16];
		end
		if (cmd.p4) begin
			d_q <= wk_neg_q ? d_base - cai_pkg::D_W'(kt_q) : d_base + cai_pkg::D_W'(kt_q);
		end
		if (cmd.load) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_nx[64] ? '1 : sum_nx[63:0];
		end
		if (cmd.m_cap) begin
			val_q <= 64'(prod[127:SH]);
		end else if (cmd.t_cap) begin
			val_q <= (|prod[127:88]) ? '1 : prod[87:24];
		end else if (cmd.y_cap) begin
			val_q <= (|prod[127:96]) ? '1 : prod[95:32];
		end else if (cmd.yr_cap) begin
			val_q <= (|div_q[63:36]) ? cai_pkg::AGE_MAX : {28'b0, div_q[35:0]};
		end else if (cmd.sat_max) begin
			val_q <= cai_pkg::AGE_MAX;
		end
		if (cmd.out_load) begin
			age_q <= val_q[cai_pkg::AGE_W-1:0];
		end
	end

	assign sts.div_done  = div_done;
	assign sts.sqrt_done = sqrt_done;
	assign sts.mul_done  = mul_done;
	assign sts.d_pos     = !d_q[cai_pkg::D_W-1] && (d_q != '0);
	assign sts.last      = i_q == cai_pkg::STEP_W'(cai_pkg::STEPS - 1);
	assign sts.h0_zero   = hub_q == '0;
	assign age_years     = age_q;
endmodule
`default_nettype wire

>>> rtl/cai_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module cai_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  out_ready,
	input  wire cai_pkg::cai_sts_t     sts,
	output logic                       in_ready,
	output logic                       out_valid,
	output cai_pkg::cai_cmd_t          cmd
);
	cai_pkg::ctrl_state_t state_q;
	cai_pkg::ctrl_state_t state_nx;
	logic out_valid_q;
	logic out_free;

	assign in_ready  = state_q == cai_pkg::ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			cai_pkg::ST_IDLE:      if (in_valid) state_nx = cai_pkg::ST_X0_GO;
			cai_pkg::ST_X0_GO:     state_nx = cai_pkg::ST_X0_WAIT;
			cai_pkg::ST_X0_WAIT:   if (sts.mul_done) state_nx = cai_pkg::ST_P1;
			cai_pkg::ST_P1:        state_nx = cai_pkg::ST_P2;
			cai_pkg::ST_P2:        state_nx = cai_pkg::ST_P3;
			cai_pkg::ST_P3:        state_nx = cai_pkg::ST_P4;
			cai_pkg::ST_P4:        state_nx = cai_pkg::ST_CHK;
			cai_pkg::ST_CHK: begin
				if (sts.d_pos) begin
					state_nx = cai_pkg::ST_SQ_WAIT;
				end else begin
					state_nx = sts.last ? cai_pkg::ST_MEAN_GO : cai_pkg::ST_P1;
				end
			end
			cai_pkg::ST_SQ_WAIT:   if (sts.sqrt_done) state_nx = cai_pkg::ST_DV_WAIT;
			cai_pkg::ST_DV_WAIT: begin
				if (sts.div_done) begin
					state_nx = sts.last ? cai_pkg::ST_MEAN_GO : cai_pkg::ST_P1;
				end
			end
			cai_pkg::ST_MEAN_GO:   state_nx = cai_pkg::ST_MEAN_WAIT;
			cai_pkg::ST_MEAN_WAIT: if (sts.mul_done) state_nx = cai_pkg::ST_TM_GO;
			cai_pkg::ST_TM_GO:     state_nx = cai_pkg::ST_TM_WAIT;
			cai_pkg::ST_TM_WAIT:   if (sts.mul_done) state_nx = cai_pkg::ST_YM_GO;
			cai_pkg::ST_YM_GO:     state_nx = cai_pkg::ST_YM_WAIT;
			cai_pkg::ST_YM_WAIT:   if (sts.mul_done) state_nx = cai_pkg::ST_HD_GO;
			cai_pkg::ST_HD_GO: begin
				state_nx = sts.h0_zero ? cai_pkg::ST_DONE : cai_pkg::ST_HD_WAIT;
			end
			cai_pkg::ST_HD_WAIT:   if (sts.div_done) state_nx = cai_pkg::ST_DONE;
			cai_pkg::ST_DONE:      if (out_free) state_nx = cai_pkg::ST_IDLE;
			default:               state_nx = cai_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_sel = cai_pkg::DIV_TERM;
		cmd.mul_sel = cai_pkg::MUL_T;
		case (state_q)
			cai_pkg::ST_IDLE:    cmd.load = in_valid;
			cai_pkg::ST_X0_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = cai_pkg::MUL_X0;
			end
			cai_pkg::ST_X0_WAIT: cmd.x0_cap = sts.mul_done;
			cai_pkg::ST_P1:      cmd.p1 = 1'b1;
			cai_pkg::ST_P2:      cmd.p2 = 1'b1;
			cai_pkg::ST_P3:      cmd.p3 = 1'b1;
			cai_pkg::ST_P4:      cmd.p4 = 1'b1;
			cai_pkg::ST_CHK: begin
				cmd.sqrt_start = sts.d_pos;
				cmd.adv        = !sts.d_pos;
			end
			cai_pkg::ST_SQ_WAIT: begin
				cmd.div_start = sts.sqrt_done;
				cmd.div_sel   = cai_pkg::DIV_TERM;
			end
			cai_pkg::ST_DV_WAIT: begin
				cmd.div_sel = cai_pkg::DIV_TERM;
				cmd.acc     = sts.div_done;
				cmd.adv     = sts.div_done;
			end
			cai_pkg::ST_MEAN_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = cai_pkg::MUL_MEAN;
			end
			cai_pkg::ST_MEAN_WAIT: cmd.m_cap = sts.mul_done;
			cai_pkg::ST_TM_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = cai_pkg::MUL_T;
			end
			cai_pkg::ST_TM_WAIT: cmd.t_cap = sts.mul_done;
			cai_pkg::ST_YM_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = cai_pkg::MUL_Y;
			end
			cai_pkg::ST_YM_WAIT: cmd.y_cap = sts.mul_done;
			cai_pkg::ST_HD_GO: begin
				cmd.sat_max   = sts.h0_zero;
				cmd.div_start = !sts.h0_zero;
				cmd.div_sel   = cai_pkg::DIV_YEARS;
			end
			cai_pkg::ST_HD_WAIT: cmd.yr_cap = sts.div_done;
			cai_pkg::ST_DONE:    cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cai_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_safe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while held");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second beat taken while busy");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == cai_pkg::ST_DV_WAIT || state_q == cai_pkg::ST_HD_WAIT))
		else $error("divider finished outside a wait state");

	a_out_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == cai_pkg::ST_DONE)
		else $error("result raised outside the done state");
endmodule
`default_nettype wire

>>> rtl/cosmic_age_integrator.sv
// each slice with a positive root argument runs the slice setup, the square root
// and the bit-serial divide, any other slice the setup only; 1000 slices lie
// between the initial setup and the final scaling
// throughput: one beat at a time, the next accepted once the result is latched
// reset: arst_n clears the controller and loads the default Hubble and density registers
`timescale 1ns / 1ps
`default_nettype none
module cosmic_age_integrator (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [cai_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  wire logic [cai_pkg::CFG_W-1:0]          cfg_wdata,
	cai_in_if.sink                                  sample,
	cai_out_if.source                               result
);
	cai_pkg::cai_cmd_t cmd;
	cai_pkg::cai_sts_t sts;

	cai_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.cmd       (cmd)
	);

	cai_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.scale_factor (sample.scale_factor),
		.cmd          (cmd),
		.sts          (sts),
		.age_years    (result.age_years)
	);
endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;

	class age_board;
		logic [cai_pkg::H0_W-1:0] h0;
		logic [cai_pkg::WM_W-1:0] wm;
		logic [cai_pkg::WM_W-1:0] wv;
		logic [cai_pkg::WR_W-1:0] wr;
		logic [cai_pkg::AGE_W-1:0] ages[$];
		int checked;

		function new();
			h0 = cai_pkg::HUBBLE_RST;
			wm = cai_pkg::MATTER_RST;
			wv = cai_pkg::VACUUM_RST;
			wr = cai_pkg::RADIATION_RST;
			checked = 0;
		endfunction

		function void set_reg(cai_pkg::cfg_idx_t idx, logic [cai_pkg::CFG_W-1:0] val);
			case (idx)
				cai_pkg::CFG_HUBBLE: h0 = val[cai_pkg::H0_W-1:0];
				cai_pkg::CFG_MATTER: wm = val[cai_pkg::WM_W-1:0];
				cai_pkg::CFG_VACUUM: wv = val[cai_pkg::WM_W-1:0];
				cai_pkg::CFG_RADIATION: wr = val[cai_pkg::WR_W-1:0];
				default: ;
			endcase
		endfunction

		function bit [63:0] floor_root(bit [63:0] v);
			bit [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function bit [63:0] scaled_product(bit [63:0] p, bit [63:0] q, int s);
			bit [127:0] prod;
			prod = 128'(p) * 128'(q);
			prod = prod >> s;
			if (prod[127:64] != 0)
				return '1;
			return prod[63:0];
		endfunction

		function logic [cai_pkg::AGE_W-1:0] age_of(logic [cai_pkg::A_W-1:0] a_in);
			bit [63:0] a, x, xs, x2, x2s, x4, kterm, r, term, sum, m, t, yrs, wk_mag;
			longint wk, d;
			bit wk_neg;
			a = 64'(a_in);
			wk = (longint'(1) << 32) - longint'({wm, 16'd0}) - longint'(wr)
				- longint'({wv, 16'd0});
			wk_neg = wk < 0;
			wk_mag = wk_neg ? 64'(-wk) : 64'(wk);
			sum = 0;
			for (int i = 0; i < cai_pkg::STEPS; i++) begin
				x = ((a * 64'(2 * i + 1)) << 16) / 64'(2 * cai_pkg::STEPS);
				if (x == 0)
					x = 1;
				xs = x >> 10;
				x2 = (xs * xs) >> 12;
				x2s = x2 >> 20;
				x4 = (x2s * x2s) >> 8;
				kterm = (wk_mag * (x2 >> 24)) >> 8;
				d = longint'(64'(wr) << 16) + longint'((64'(wm) * x) >> 8)
					+ longint'(64'(wv) * (x4 >> 16));
				if (wk_neg)
					d = d - longint'(kterm);
				else
					d = d + longint'(kterm);
				if (d <= 0)
					continue;
				r = floor_root(64'(d));
				if (r == 0)
					continue;
				term = (x << 16) / r;
				sum = (sum > ~64'd0 - term) ? ~64'd0 : sum + term;
			end
			m = sum / 64'(cai_pkg::STEPS);
			t = scaled_product(m, a, 24);
			if (h0 == 0) begin
				yrs = cai_pkg::AGE_MAX;
			end else begin
				yrs = scaled_product(t, cai_pkg::YEARS_NUM, 32) / 64'(h0);
				if (yrs > cai_pkg::AGE_MAX)
					yrs = cai_pkg::AGE_MAX;
			end
			return yrs[cai_pkg::AGE_W-1:0];
		endfunction

		function void note_sample(logic [cai_pkg::A_W-1:0] a);
			ages.push_back(age_of(a));
		endfunction

		function bit check_age(logic [cai_pkg::AGE_W-1:0] got, output string msg);
			logic [cai_pkg::AGE_W-1:0] want;
			checked++;
			if (ages.size() == 0) begin
				msg = $sformatf("unexpected result beat, age_years=%0d", got);
				return 1;
			end
			want = ages.pop_front();
			if (got !== want) begin
				msg = $sformatf("age_years mismatch: got %0d want %0d", got, want);
				return 1;
			end
			return 0;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [cai_pkg::CFG_IDX_W-1:0] cfg_addr;
	logic [cai_pkg::CFG_W-1:0] cfg_wdata;

	cai_in_if in_ch();
	cai_out_if out_ch();

	cosmic_age_integrator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.sample(in_ch),
		.result(out_ch)
	);

	age_board board;
	int errors;
	int sent;
	int cfg_phases;
	bit hold_done;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report(string msg);
		errors++;
		$display("mismatch: %s", msg);
	endtask

	function automatic int pick_gap();
		if ($urandom_range(3, 0) == 0)
			return 0;
		if ($urandom_range(9, 0) == 0)
			return $urandom_range(60, 10);
		return $urandom_range(3, 0);
	endfunction

	task automatic cfg_write(cai_pkg::cfg_idx_t idx, logic [cai_pkg::CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic send(logic [cai_pkg::A_W-1:0] a);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.scale_factor <= a;
		do
			@(posedge clk);
		while (!in_ch.ready);
		board.note_sample(a);
		sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [cai_pkg::A_W-1:0] rand_scale();
		case ($urandom_range(5, 0))
			0: return cai_pkg::A_W'($urandom_range(4096, 1));
			1: return cai_pkg::A_W'($urandom);
			default: return cai_pkg::A_W'($urandom_range(33554432, 1));
		endcase
	endfunction

	task automatic send_random(int n);
		repeat (n) send(rand_scale());
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (board.ages.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// result side
	initial begin
		string msg;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				if (board.check_age(out_ch.age_years, msg))
					report(msg);
			if (!hold_done && sent >= 4) begin
				hold_done = 1;
				out_ch.ready <= 1'b0;
				repeat (250000) @(posedge clk);
			end
			if ($urandom_range(7, 0) < 2)
				out_ch.ready <= 1'b0;
			else
				out_ch.ready <= 1'b1;
		end
	end

	// watchdog
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle = 0;
			else
				idle++;
			if (idle >= 1000000) begin
				$display("watchdog expired with %0d results pending", board.ages.size());
				$display("** cosmic_age_integrator: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		board = new();
		errors = 0;
		sent = 0;
		cfg_phases = 0;
		hold_done = 0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_addr <= cai_pkg::CFG_HUBBLE;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.scale_factor <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default densities
		send('0);
		send(cai_pkg::A_W'(1));
		send(cai_pkg::A_W'(2));
		send(cai_pkg::A_W'(100));
		send(cai_pkg::A_W'(1 << 24));
		send(cai_pkg::A_W'(1 << 25));
		send('1);
		send(cai_pkg::A_W'(26'h2AAAAAA));
		send(cai_pkg::A_W'(26'h1555555));
		send_random(20);
		drain();

		// zero hubble constant
		cfg_write(cai_pkg::CFG_HUBBLE, '0);
		send(cai_pkg::A_W'(1 << 24));
		send(cai_pkg::A_W'(1));
		send('0);
		drain();

		// empty universe, fastest hubble
		cfg_write(cai_pkg::CFG_HUBBLE, cai_pkg::CFG_W'(255));
		cfg_write(cai_pkg::CFG_MATTER, '0);
		cfg_write(cai_pkg::CFG_VACUUM, '0);
		cfg_write(cai_pkg::CFG_RADIATION, '0);
		send(cai_pkg::A_W'(1));
		send(cai_pkg::A_W'(1 << 25));
		send('1);
		send_random(10);
		drain();

		// overdense: negative curvature, though the root argument still stays positive
		cfg_write(cai_pkg::CFG_HUBBLE, cai_pkg::CFG_W'(1));
		cfg_write(cai_pkg::CFG_MATTER, cai_pkg::CFG_W'(16'hFFFF));
		cfg_write(cai_pkg::CFG_VACUUM, cai_pkg::CFG_W'(16'hFFFF));
		cfg_write(cai_pkg::CFG_RADIATION, '1);
		send(cai_pkg::A_W'(1));
		send(cai_pkg::A_W'(1 << 24));
		send(cai_pkg::A_W'(1 << 25));
		send('1);
		send_random(2);
		drain();

		repeat (3) begin
			cfg_write(cai_pkg::CFG_HUBBLE, cai_pkg::CFG_W'($urandom_range(255, 1)));
			cfg_write(cai_pkg::CFG_MATTER, cai_pkg::CFG_W'($urandom));
			cfg_write(cai_pkg::CFG_VACUUM, cai_pkg::CFG_W'($urandom));
			cfg_write(cai_pkg::CFG_RADIATION, cai_pkg::CFG_W'($urandom));
			cfg_phases++;
			send_random(15);
			drain();
		end

		repeat (200) @(posedge clk);
		$display("run covered %0d scale factors, %0d results checked", sent, board.checked);
		$display("settings: defaults, zero and extreme hubble, empty and overdense, %0d random",
			cfg_phases);
		if (errors == 0 && board.ages.size() == 0) begin
			$display("** cosmic_age_integrator: PASSED **");
		end else begin
			$display("** cosmic_age_integrator: FAILED **");
		end
		$finish;
	end
endmodule
